[hdl/flmq_pkg.sv]
// ----------------------------------------------------------------------------
// flmq_pkg
// Shared types and constants for the five-level tagged message queue.
// ----------------------------------------------------------------------------
package flmq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int LEVELS_DEF        = 5;
  localparam int SENDER_WIDTH_DEF  = 8;
  localparam int PAYLOAD_WIDTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int LEVEL_W = 3;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 3;
  localparam int MAX_OUT = 64;

  typedef enum logic [OP_W-1:0] {
    OP_SEND     = 2'd0,
    OP_ANNOUNCE = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_PROMOTE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MSG     = 3'd0,
    KIND_SENT    = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_REMOVED = 3'd4,
    KIND_PROMOTED = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND_WR,
    S_ANN_RD,
    S_ANN_PROC,
    S_WALK_START,
    S_WALK,
    S_EMIT
  } state_t;

endpackage

[hdl/five_level_tagged_message_queue_top.sv]
// ----------------------------------------------------------------------------
// five_level_tagged_message_queue_top
// Priority message queue: five FIFO levels linked through one shared store.
//
// Input channel (in_valid/in_stall) takes one command item: send, announce,
// remove sender or promote sender. Output channel (out_valid/out_stall)
// returns result items; the final result of a command carries last = 1.
// Commands are handled one at a time; in_stall stays high while a command
// is in progress. A finished result sits in the output register, so the
// next command is taken while it waits to be accepted.
// Steps per command:
//   send             read the free-list head's link, then write the entry
//   announce         one store read and one emitted result per message
//   remove, promote  one store read per stored entry on the walked levels,
//                    plus a start step per walked level
// The store is three single-port-write, registered-read memories; the walk
// rate is set by one store read per cycle. Level heads, tails and counts
// live in registers. Reset empties all levels at once; no clearing pass is
// needed because unused entries are handed out by a fill counter first.
// When the receiver stalls, the result and the command hold until taken.
// ----------------------------------------------------------------------------
module five_level_tagged_message_queue_top
  import flmq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int LEVELS        = LEVELS_DEF,
  parameter int SENDER_WIDTH  = SENDER_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          operation,
  input  logic [SENDER_WIDTH-1:0]  sender_id,
  input  logic [LEVEL_W-1:0]       level,
  input  logic [PAYLOAD_WIDTH-1:0] payload,
  input  logic [COUNT_W-1:0]       count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [KIND_W-1:0]        result_kind,
  output logic [SENDER_WIDTH-1:0]  msg_sender,
  output logic [LEVEL_W-1:0]       msg_level,
  output logic [PAYLOAD_WIDTH-1:0] msg_payload,
  output logic [COUNT_W-1:0]       affected_count,
  output logic                     last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [CNT_W-1:0]   CAP_C   = CNT_W'(CAPACITY);
  localparam logic [LV_W-1:0]    LV_TOP  = LV_W'(LEVELS - 1);
  localparam logic [LV_W-1:0]    LV_SUB  = LV_W'(LEVELS - 2);
  localparam logic [COUNT_W-1:0] K_FINAL = COUNT_W'(MAX_OUT - 1);

  // store
  logic [SENDER_WIDTH-1:0]  sender_mem  [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] payload_mem [CAPACITY];
  logic [IDX_W-1:0]         next_mem    [CAPACITY];
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [SENDER_WIDTH-1:0]  q_sender;
  logic [PAYLOAD_WIDTH-1:0] q_payload;
  logic [IDX_W-1:0]         q_next;
  logic                     ent_we;
  logic [IDX_W-1:0]         ent_wa;
  logic                     nx_we;
  logic [IDX_W-1:0]         nx_wa;
  logic [IDX_W-1:0]         nx_wd;

  // control registers
  state_t                   state, state_next;
  op_t                      op_r, op_r_next;
  logic [SENDER_WIDTH-1:0]  snd_r, snd_r_next;
  logic [LV_W-1:0]          lvl_r, lvl_r_next;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_r_next;
  logic [COUNT_W-1:0]       cnt_r, cnt_r_next;
  logic [COUNT_W-1:0]       k_r, k_r_next;
  kind_t                    kind_r, kind_r_next;
  logic [IDX_W-1:0]         head [LEVELS];
  logic [IDX_W-1:0]         head_next [LEVELS];
  logic [IDX_W-1:0]         tail [LEVELS];
  logic [IDX_W-1:0]         tail_next [LEVELS];
  logic [CNT_W-1:0]         lcount [LEVELS];
  logic [CNT_W-1:0]         lcount_next [LEVELS];
  logic [IDX_W-1:0]         free_head, free_head_next;
  logic [CNT_W-1:0]         fresh, fresh_next;
  logic [CNT_W-1:0]         stored, stored_next;
  logic [LV_W-1:0]          walk_lv, walk_lv_next;
  logic [CNT_W-1:0]         walk_left, walk_left_next;
  logic [CNT_W-1:0]         hits, hits_next;
  logic [IDX_W-1:0]         cur, cur_next;

  // output register
  logic                     out_valid_next;
  logic [KIND_W-1:0]        result_kind_next;
  logic [SENDER_WIDTH-1:0]  msg_sender_next;
  logic [LEVEL_W-1:0]       msg_level_next;
  logic [PAYLOAD_WIDTH-1:0] msg_payload_next;
  logic [COUNT_W-1:0]       affected_count_next;
  logic                     last_next;

  logic                     out_free;
  logic [LV_W-1:0]          top_lv;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    top_lv = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lcount[i] != '0) top_lv = LV_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_sender  <= sender_mem[rd_addr];
      q_payload <= payload_mem[rd_addr];
      q_next    <= next_mem[rd_addr];
    end
    if (ent_we) begin
      sender_mem[ent_wa]  <= snd_r;
      payload_mem[ent_wa] <= pay_r;
    end
    if (nx_we) next_mem[nx_wa] <= nx_wd;
  end

  always_comb begin
    logic             accept;
    logic             use_fresh;
    logic [IDX_W-1:0] idx;
    logic [LV_W-1:0]  dst;
    logic             hit;
    logic             lv_done;

    accept    = in_valid && !in_stall;
    use_fresh = (fresh != CAP_C);
    idx       = '0;
    dst       = '0;
    hit       = 1'b0;
    lv_done   = 1'b0;

    state_next     = state;
    op_r_next      = op_r;
    snd_r_next     = snd_r;
    lvl_r_next     = lvl_r;
    pay_r_next     = pay_r;
    cnt_r_next     = cnt_r;
    k_r_next       = k_r;
    kind_r_next    = kind_r;
    head_next      = head;
    tail_next      = tail;
    lcount_next    = lcount;
    free_head_next = free_head;
    fresh_next     = fresh;
    stored_next    = stored;
    walk_lv_next   = walk_lv;
    walk_left_next = walk_left;
    hits_next      = hits;
    cur_next       = cur;

    rd_en   = 1'b0;
    rd_addr = cur;
    ent_we  = 1'b0;
    ent_wa  = '0;
    nx_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = '0;

    out_valid_next      = out_valid && out_stall;
    result_kind_next    = result_kind;
    msg_sender_next     = msg_sender;
    msg_level_next      = msg_level;
    msg_payload_next    = msg_payload;
    affected_count_next = affected_count;
    last_next           = last;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next  = op_t'(operation);
          snd_r_next = sender_id;
          pay_r_next = payload;
          cnt_r_next = count;
          k_r_next   = '0;
          hits_next  = '0;
          if (32'(level) >= LEVELS) lvl_r_next = LV_TOP;
          else                      lvl_r_next = LV_W'(level);
          case (op_t'(operation))
            OP_SEND: begin
              if (stored == CAP_C) begin
                kind_r_next = KIND_DROPPED;
                state_next  = S_EMIT;
              end else begin
                // pop the free list head's link in case it is needed
                rd_en      = 1'b1;
                rd_addr    = free_head;
                state_next = S_SEND_WR;
              end
            end
            OP_ANNOUNCE: begin
              if (count == '0 || stored == '0) begin
                kind_r_next = KIND_NONE;
                state_next  = S_EMIT;
              end else begin
                state_next = S_ANN_RD;
              end
            end
            OP_REMOVE: begin
              walk_lv_next = '0;
              state_next   = S_WALK_START;
            end
            default: begin
              walk_lv_next = LV_SUB;
              state_next   = S_WALK_START;
            end
          endcase
        end
      end

      S_SEND_WR: begin
        if (use_fresh) begin
          idx        = fresh[IDX_W-1:0];
          fresh_next = fresh + 1'b1;
        end else begin
          idx            = free_head;
          free_head_next = q_next;
        end
        ent_we = 1'b1;
        ent_wa = idx;
        if (lcount[lvl_r] != '0) begin
          nx_we = 1'b1;
          nx_wa = tail[lvl_r];
          nx_wd = idx;
        end else begin
          head_next[lvl_r] = idx;
        end
        tail_next[lvl_r]   = idx;
        lcount_next[lvl_r] = lcount[lvl_r] + 1'b1;
        stored_next        = stored + 1'b1;
        kind_r_next        = KIND_SENT;
        state_next         = S_EMIT;
      end

      S_ANN_RD: begin
        rd_en        = 1'b1;
        rd_addr      = head[top_lv];
        cur_next     = head[top_lv];
        walk_lv_next = top_lv;
        state_next   = S_ANN_PROC;
      end

      S_ANN_PROC: begin
        if (out_free) begin
          out_valid_next      = 1'b1;
          result_kind_next    = KIND_MSG;
          msg_sender_next     = q_sender;
          msg_level_next      = LEVEL_W'(walk_lv);
          msg_payload_next    = q_payload;
          affected_count_next = '0;
          last_next = (stored == CNT_W'(1)) || (cnt_r == COUNT_W'(1)) || (k_r == K_FINAL);
          head_next[walk_lv]   = q_next;
          lcount_next[walk_lv] = lcount[walk_lv] - 1'b1;
          stored_next          = stored - 1'b1;
          // return the entry to the free list
          nx_we          = 1'b1;
          nx_wa          = cur;
          nx_wd          = free_head;
          free_head_next = cur;
          cnt_r_next     = cnt_r - 1'b1;
          k_r_next       = k_r + 1'b1;
          state_next     = last_next ? S_IDLE : S_ANN_RD;
        end
      end

      S_WALK_START: begin
        walk_left_next       = lcount[walk_lv];
        lcount_next[walk_lv] = '0;
        cur_next             = head[walk_lv];
        if (lcount[walk_lv] != '0) begin
          rd_en      = 1'b1;
          rd_addr    = head[walk_lv];
          state_next = S_WALK;
        end else begin
          lv_done = 1'b1;
        end
      end

      S_WALK: begin
        hit = (q_sender == snd_r);
        if (hit) hits_next = hits + 1'b1;
        if (hit && op_r == OP_REMOVE) begin
          nx_we          = 1'b1;
          nx_wa          = cur;
          nx_wd          = free_head;
          free_head_next = cur;
          stored_next    = stored - 1'b1;
        end else begin
          // rebuild this level, or append to the level above
          dst = hit ? walk_lv + 1'b1 : walk_lv;
          if (lcount_next[dst] != '0) begin
            nx_we = 1'b1;
            nx_wa = tail[dst];
            nx_wd = cur;
          end else begin
            head_next[dst] = cur;
          end
          tail_next[dst]   = cur;
          lcount_next[dst] = lcount_next[dst] + 1'b1;
        end
        walk_left_next = walk_left - 1'b1;
        if (walk_left != CNT_W'(1)) begin
          rd_en    = 1'b1;
          rd_addr  = q_next;
          cur_next = q_next;
        end else begin
          lv_done = 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_next      = 1'b1;
          result_kind_next    = kind_r;
          msg_sender_next     = '0;
          msg_level_next      = '0;
          msg_payload_next    = '0;
          affected_count_next = COUNT_W'(hits);
          last_next           = 1'b1;
          state_next          = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // advance to the next level of a remove or promote walk
    if (lv_done) begin
      if (op_r == OP_REMOVE) begin
        if (walk_lv == LV_TOP) begin
          kind_r_next = KIND_REMOVED;
          state_next  = S_EMIT;
        end else begin
          walk_lv_next = walk_lv + 1'b1;
          state_next   = S_WALK_START;
        end
      end else begin
        if (walk_lv == '0) begin
          kind_r_next = KIND_PROMOTED;
          state_next  = S_EMIT;
        end else begin
          walk_lv_next = walk_lv - 1'b1;
          state_next   = S_WALK_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      free_head <= '0;
      fresh     <= '0;
      stored    <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i]   <= '0;
        tail[i]   <= '0;
        lcount[i] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      stored    <= stored_next;
      head      <= head_next;
      tail      <= tail_next;
      lcount    <= lcount_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_r_next;
    snd_r          <= snd_r_next;
    lvl_r          <= lvl_r_next;
    pay_r          <= pay_r_next;
    cnt_r          <= cnt_r_next;
    k_r            <= k_r_next;
    kind_r         <= kind_r_next;
    walk_lv        <= walk_lv_next;
    walk_left      <= walk_left_next;
    hits           <= hits_next;
    cur            <= cur_next;
    result_kind    <= result_kind_next;
    msg_sender     <= msg_sender_next;
    msg_level      <= msg_level_next;
    msg_payload    <= msg_payload_next;
    affected_count <= affected_count_next;
    last           <= last_next;
  end

endmodule

[sim/five_level_tagged_message_queue_top_test.sv]
// ----------------------------------------------------------------------------
// five_level_tagged_message_queue_top_test
// Self-checking bench for the five-level tagged message queue. Random and
// directed commands go in under random gaps; a behavioral copy of the level
// lists predicts every result, which is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module five_level_tagged_message_queue_top_test
  import flmq_pkg::*;
;

  localparam int NLEV  = 5;
  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sender;
    logic [2:0]  lvl;
    logic [15:0] handle;
    logic [6:0]  affected;
    logic        fin;
  } result_t;

  typedef struct packed {
    logic [7:0]  sender;
    logic [15:0] handle;
  } message_t;

  class queue_scoreboard;
    message_t levels[NLEV][$];
    result_t  pending[$];
    int       errors;

    function int stored();
      int n;
      n = 0;
      for (int l = 0; l < NLEV; l++) n += levels[l].size();
      return n;
    endfunction

    function void push(logic [2:0] kind, message_t m, int lvl, int aff);
      result_t r;
      r.kind = kind;
      r.sender = m.sender;
      r.lvl = lvl[2:0];
      r.handle = m.handle;
      r.affected = aff[6:0];
      r.fin = 1'b0;
      pending.push_back(r);
    endfunction

    // Predict the results of one accepted command.
    function void note_command(op_t op, logic [7:0] snd, logic [2:0] lvl,
                               logic [15:0] pay, logic [6:0] cnt);
      message_t m, zero, keep[$];
      int lv, n, hits, first;
      zero = '0;
      first = pending.size();
      case (op)
        OP_SEND: begin
          lv = (lvl >= NLEV) ? NLEV - 1 : lvl;
          if (stored() >= DEPTH) begin
            push(KIND_DROPPED, zero, 0, 0);
          end else begin
            m.sender = snd;
            m.handle = pay;
            levels[lv].push_back(m);
            push(KIND_SENT, zero, 0, 0);
          end
        end
        OP_ANNOUNCE: begin
          n = cnt;
          hits = 0;
          for (lv = NLEV - 1; lv >= 0; lv--) begin
            while (levels[lv].size() > 0 && n > 0 && hits < MAX_OUT) begin
              m = levels[lv].pop_front();
              push(KIND_MSG, m, lv, 0);
              n--;
              hits++;
            end
          end
          if (hits == 0) push(KIND_NONE, zero, 0, 0);
        end
        OP_REMOVE: begin
          hits = 0;
          for (lv = 0; lv < NLEV; lv++) begin
            keep = {};
            for (int i = 0; i < levels[lv].size(); i++) begin
              if (levels[lv][i].sender == snd) hits++;
              else keep.push_back(levels[lv][i]);
            end
            levels[lv] = keep;
          end
          push(KIND_REMOVED, zero, 0, hits);
        end
        default: begin
          hits = 0;
          for (lv = NLEV - 2; lv >= 0; lv--) begin
            keep = {};
            for (int i = 0; i < levels[lv].size(); i++) begin
              if (levels[lv][i].sender == snd) begin
                hits++;
                levels[lv + 1].push_back(levels[lv][i]);
              end else begin
                keep.push_back(levels[lv][i]);
              end
            end
            levels[lv] = keep;
          end
          push(KIND_PROMOTED, zero, 0, hits);
        end
      endcase
      if (pending.size() > first) pending[pending.size() - 1].fin = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
      if (got.sender !== want.sender)
        $display("%0t: msg_sender expected %0d actual %0d", $time, want.sender, got.sender);
      if (got.lvl !== want.lvl)
        $display("%0t: msg_level expected %0d actual %0d", $time, want.lvl, got.lvl);
      if (got.handle !== want.handle)
        $display("%0t: msg_payload expected %0d actual %0d", $time, want.handle,
                 got.handle);
      if (got.affected !== want.affected)
        $display("%0t: affected_count expected %0d actual %0d", $time, want.affected,
                 got.affected);
      if (got.fin !== want.fin)
        $display("%0t: last expected %0d actual %0d", $time, want.fin, got.fin);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  operation;
  logic [7:0]  sender_id;
  logic [2:0]  level;
  logic [15:0] payload;
  logic [6:0]  count;
  logic        out_valid, out_stall;
  logic [2:0]  result_kind;
  logic [7:0]  msg_sender;
  logic [2:0]  msg_level;
  logic [15:0] msg_payload;
  logic [6:0]  affected_count;
  logic        last;

  queue_scoreboard board;
  int  idle_cycles;
  bit  stim_done;

  five_level_tagged_message_queue_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sender_id(sender_id), .level(level),
    .payload(payload), .count(count),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .msg_sender(msg_sender), .msg_level(msg_level),
    .msg_payload(msg_payload), .affected_count(affected_count), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 8) return $urandom_range(2, 6);
    return $urandom_range(10, 40);
  endfunction

  // Drive one command and hold it until taken.
  task automatic send_command(op_t op, logic [7:0] snd, logic [2:0] lvl,
                              logic [15:0] pay, logic [6:0] cnt);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    sender_id <= snd;
    level     <= lvl;
    payload   <= pay;
    count     <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(op, snd, lvl, pay, cnt);
  endtask

  // Small sender pool so that remove and promote usually hit something.
  function automatic logic [7:0] pick_sender();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 5));
    return 8'($urandom);
  endfunction

  // Receiver side: random stall, check on accept.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result({result_kind, msg_sender, msg_level, msg_payload,
                            affected_count, last});
      out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r, op;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    sender_id = '0;
    level = '0;
    payload = '0;
    count = '0;
    idle_cycles = 0;
    stim_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty announce, extremes, saturated level, fill to full.
    send_command(OP_ANNOUNCE, 8'd0, 3'd0, 16'd0, 7'd5);
    send_command(OP_REMOVE, 8'd9, 3'd0, 16'd0, 7'd0);
    send_command(OP_PROMOTE, 8'd9, 3'd0, 16'd0, 7'd0);
    send_command(OP_SEND, 8'hFF, 3'd7, 16'hFFFF, 7'h7F);
    send_command(OP_SEND, 8'h00, 3'd0, 16'h0000, 7'd0);
    send_command(OP_SEND, 8'h5A, 3'd5, 16'hA5A5, 7'd0);
    send_command(OP_SEND, 8'h00, 3'd3, 16'h1234, 7'd0);
    send_command(OP_PROMOTE, 8'h00, 3'd0, 16'd0, 7'd0);
    send_command(OP_PROMOTE, 8'hFF, 3'd0, 16'd0, 7'd0);
    send_command(OP_ANNOUNCE, 8'd0, 3'd0, 16'd0, 7'd0);
    send_command(OP_ANNOUNCE, 8'd0, 3'd0, 16'd0, 7'd2);
    send_command(OP_REMOVE, 8'h00, 3'd0, 16'd0, 7'd0);
    for (int i = 0; i < 66; i++)
      send_command(OP_SEND, 8'(i % 3), 3'(i % 6), 16'($urandom), 7'd0);
    send_command(OP_ANNOUNCE, 8'd0, 3'd0, 16'd0, 7'd127);
    send_command(OP_ANNOUNCE, 8'd0, 3'd0, 16'd0, 7'd64);

    for (int i = 0; i < 390; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 55) ? OP_SEND : (r < 75) ? OP_ANNOUNCE : (r < 88) ? OP_PROMOTE : OP_REMOVE;
      if (op == OP_ANNOUNCE)
        send_command(OP_ANNOUNCE, 8'($urandom), 3'($urandom), 16'($urandom),
                     ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6)));
      else
        send_command(op_t'(op), pick_sender(), 3'($urandom), 16'($urandom),
                     7'($urandom));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (stim_done && board.pending.size() == 0) begin
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
          $display("TB_OK");
        end else begin
          $display("TB_ERROR");
        end
        $finish;
      end
    end
  end

endmodule

[five_level_tagged_message_queue_top.f]
hdl/flmq_pkg.sv
hdl/five_level_tagged_message_queue_top.sv
sim/five_level_tagged_message_queue_top_test.sv
